// ----- design/segmented_memory_access_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Segmented memory access unit: assertion macros
// Shared property macros for the checker of the segmented memory access unit.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_MEMORY_ACCESS_UNIT_DEFINES_SVH
`define SEGMENTED_MEMORY_ACCESS_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge.
`define SMAU_ASSERT_NOW(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("segmented memory access unit: check failed");

// Next-cycle implication, checked at every rising clock edge.
`define SMAU_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("segmented memory access unit: check failed");

`endif

// ----- design/smau_pkg.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit package
// Sizes, request codes and the classified operation passed front to back.
// ----------------------------------------------------------------------------
package smau_pkg;

  // Storage sizes.
  localparam int MEM_BYTES   = 16384;
  localparam int SEGMENTS    = 8;
  localparam int MEM_AW      = $clog2(MEM_BYTES);
  localparam int SEG_AW      = $clog2(SEGMENTS);
  localparam int MAX_BYTES   = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Request type codes on the req_type port.
  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_DESC  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // What the back end has to do with a classified request.
  typedef enum logic [1:0] {
    OP_NOP   = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_kind_t;

  // Classified request, as held in the queue between front and back.
  typedef struct packed {
    op_kind_t    kind;
    logic        fault;
    logic [15:0] phys;
    logic [2:0]  count;
    logic [31:0] data;
  } op_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_ACCESS = 2'd1,
    BK_DRAIN  = 2'd2,
    BK_DONE   = 2'd3
  } back_state_t;

endpackage

// ----- design/smau_front.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit: front end
// Accepts requests, keeps the descriptor table, forms the physical address
// and classifies each request, including the bounds check, for the back end.
// ----------------------------------------------------------------------------
module smau_front
  import smau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [2:0]         seg_index,
  input  logic signed [15:0] ptr_offset,
  input  logic signed [15:0] extra_offset,
  input  logic [2:0]         byte_count,
  input  logic [31:0]        write_data,
  input  logic [15:0]        desc_base,
  input  logic [15:0]        desc_size,
  input  queue_status_t      q_status,
  output logic               q_push,
  output op_t                q_op
);

  logic [31:0] seg_table [SEGMENTS];

  logic        accept;
  logic        seg_ok;
  logic [31:0] desc;
  logic [15:0] phys_calc;
  logic [2:0]  count_sat;
  op_kind_t    kind_calc;

  logic        hold_valid;
  op_kind_t    hold_kind;
  logic [15:0] hold_phys;
  logic [15:0] hold_base;
  logic [16:0] hold_end;
  logic [2:0]  hold_count;
  logic [31:0] hold_data;
  logic        hold_fault;

  // The holding register frees up whenever its request moves into the queue.
  assign full   = hold_valid && q_status.full;
  assign accept = push && !full;
  assign q_push = hold_valid && !q_status.full;

  // Descriptor lookup; a slot beyond the table reads as base 0, size 0.
  assign seg_ok = 32'(seg_index) < SEGMENTS;
  assign desc   = seg_ok ? seg_table[seg_index[SEG_AW-1:0]] : 32'd0;

  // Physical address of the first byte, wrapping modulo 2^16.
  assign phys_calc = desc[31:16] + $unsigned(ptr_offset) + $unsigned(extra_offset);
  assign count_sat = (byte_count > 3'(MAX_BYTES)) ? 3'(MAX_BYTES) : byte_count;

  // Map the request type onto the work the back end does.
  always_comb begin
    case (req_type)
      REQ_READ:  kind_calc = OP_READ;
      REQ_WRITE: kind_calc = OP_WRITE;
      default:   kind_calc = OP_NOP;
    endcase
  end

  // Descriptor table: written by descriptor requests as they are accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SEGMENTS; i++) begin
        seg_table[i] <= 32'd0;
      end
    end else if (accept && req_type == REQ_DESC && seg_ok) begin
      seg_table[seg_index[SEG_AW-1:0]] <= {desc_base, desc_size};
    end
  end

  // Holding register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (q_push) begin
      hold_valid <= 1'b0;
    end
  end

  // Holding register payload, captured with the descriptor it uses.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_kind  <= kind_calc;
      hold_phys  <= (kind_calc == OP_NOP) ? 16'd0 : phys_calc;
      hold_base  <= desc[31:16];
      hold_end   <= {1'b0, desc[31:16]} + {1'b0, desc[15:0]};
      hold_count <= count_sat;
      hold_data  <= write_data;
    end
  end

  // Bounds check of every touched byte against the segment and the memory.
  always_comb begin
    logic [15:0] addr;
    logic        bad;
    hold_fault = 1'b0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      addr = hold_phys + 16'(i);
      bad  = (addr < hold_base) || ({1'b0, addr} >= hold_end) ||
             ({1'b0, addr} >= 17'(MEM_BYTES));
      if ((3'(i) < hold_count) && bad) begin
        hold_fault = 1'b1;
      end
    end
    if (hold_kind == OP_NOP) begin
      hold_fault = 1'b0;
    end
  end

  // Classified request toward the queue.
  assign q_op = '{kind:  hold_kind,
                  fault: hold_fault,
                  phys:  hold_phys,
                  count: hold_count,
                  data:  hold_data};

endmodule

// ----- design/smau_queue.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit: decoupling queue
// A short first-in first-out queue of classified requests between the
// front end and the back end.
// ----------------------------------------------------------------------------
module smau_queue
  import smau_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  op_t           push_op,
  input  logic          pop,
  output op_t           head_op,
  output queue_status_t status
);

  op_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push_ok;
  logic              pop_ok;

  assign status.full  = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (fill == '0);
  assign push_ok      = push && !status.full;
  assign pop_ok       = pop && !status.empty;
  assign head_op      = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        fill <= fill + 1'b1;
      end else if (pop_ok && !push_ok) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_op;
    end
  end

endmodule

// ----- design/smau_back.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit: back end
// Carries out classified requests one byte per cycle on the byte memory and
// holds the finished result in an output register until it is popped.
// ----------------------------------------------------------------------------
module smau_back
  import smau_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  op_t         q_op,
  output logic        q_pop,
  input  logic        pop,
  output logic        empty,
  output logic [31:0] read_data,
  output logic        fault,
  output logic [15:0] phys_addr
);

  logic [7:0] mem [MEM_BYTES];

  back_state_t state;
  back_state_t state_next;

  op_t         cur;
  logic [1:0]  idx;
  logic [31:0] shreg;
  logic [31:0] acc;
  logic        rd_pending;
  logic [7:0]  mem_q;

  logic        res_valid;
  logic [31:0] res_data;
  logic        res_fault;
  logic [15:0] res_phys;

  logic [15:0] addr;
  logic        last_byte;
  logic        touches;
  logic        mem_we;
  logic        res_load;

  assign addr      = cur.phys + {14'd0, idx};
  assign last_byte = ({1'b0, idx} + 3'd1) == cur.count;
  assign touches   = (q_op.kind != OP_NOP) && !q_op.fault && (q_op.count != 3'd0);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = touches ? BK_ACCESS : BK_DONE;
        end
      end
      BK_ACCESS: begin
        if (last_byte) begin
          state_next = (cur.kind == OP_READ) ? BK_DRAIN : BK_DONE;
        end
      end
      BK_DRAIN: begin
        state_next = BK_DONE;
      end
      BK_DONE: begin
        if (!res_valid || pop) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    res_load = 1'b0;
    case (state)
      BK_IDLE:   q_pop    = !q_empty;
      BK_ACCESS: mem_we   = (cur.kind == OP_WRITE);
      BK_DONE:   res_load = !res_valid || pop;
      default:   q_pop    = 1'b0;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      rd_pending <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == BK_ACCESS) && (cur.kind == OP_READ);
    end
  end

  // Current request: load, byte index, write data shifter and read assembly.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur   <= q_op;
      idx   <= 2'd0;
      acc   <= 32'd0;
      shreg <= q_op.data << {3'(MAX_BYTES) - q_op.count, 3'b000};
    end else begin
      if (state == BK_ACCESS) begin
        idx   <= idx + 2'd1;
        shreg <= {shreg[23:0], 8'd0};
      end
      if (rd_pending) begin
        acc <= {acc[23:0], mem_q};
      end
    end
  end

  // Byte memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr[MEM_AW-1:0]] <= shreg[31:24];
    end
    mem_q <= mem[addr[MEM_AW-1:0]];
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_data  <= acc;
      res_fault <= cur.fault;
      res_phys  <= cur.phys;
    end
  end

  assign empty     = !res_valid;
  assign read_data = res_data;
  assign fault     = res_fault;
  assign phys_addr = res_phys;

endmodule

// ----- design/segmented_memory_access_unit.sv -----
// A request passes the front holding register and the queue, so new requests are taken
// while the back end works. The back end goes from idle through one access state per
// byte, a drain state after reads, to the done state, which loads the result register;
// descriptor writes, faults and zero counts skip access, which moves one byte per cycle.
// Reset clears the descriptor table, the queue and the result register; memory contents
// stay undefined until written.
// ----------------------------------------------------------------------------
// Segmented memory access unit
// Segment base and limit translation over a byte memory, with a front end that
// classifies requests and a back end that performs the byte accesses.
// ----------------------------------------------------------------------------
module segmented_memory_access_unit
  import smau_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic [2:0]         seg_index,
  input  logic signed [15:0] ptr_offset,
  input  logic signed [15:0] extra_offset,
  input  logic [2:0]         byte_count,
  input  logic [31:0]        write_data,
  input  logic [15:0]        desc_base,
  input  logic [15:0]        desc_size,
  output logic               empty,
  input  logic               pop,
  output logic [31:0]        read_data,
  output logic               fault,
  output logic [15:0]        phys_addr
);

  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;
  op_t           q_in_op;
  op_t           q_head_op;

  // Front end: descriptor table, address formation and bounds check.
  smau_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .seg_index    (seg_index),
    .ptr_offset   (ptr_offset),
    .extra_offset (extra_offset),
    .byte_count   (byte_count),
    .write_data   (write_data),
    .desc_base    (desc_base),
    .desc_size    (desc_size),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_op         (q_in_op)
  );

  // Queue between the two halves.
  smau_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_op (q_in_op),
    .pop     (q_pop),
    .head_op (q_head_op),
    .status  (q_status)
  );

  // Back end: byte memory and result register.
  smau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_status.empty),
    .q_op      (q_head_op),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .read_data (read_data),
    .fault     (fault),
    .phys_addr (phys_addr)
  );

endmodule

// ----- design/smau_checker.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit: port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "segmented_memory_access_unit_defines.svh"

module smau_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] read_data,
  input logic        fault,
  input logic [15:0] phys_addr
);

  // Coming out of reset, no result waits and a request can be taken.
  `SMAU_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, empty && !full)

  // A faulting access returns no data.
  `SMAU_ASSERT_NOW(a_fault_no_data, clk, rst, !empty && fault, read_data == 32'd0)

  // A result that is not taken stays offered.
  `SMAU_ASSERT_NEXT(a_result_held, clk, rst, !empty && !pop, !empty)

  // A result that is not taken keeps its fields.
  `SMAU_ASSERT_NEXT(a_result_stable, clk, rst, !empty && !pop,
    $stable(read_data) && $stable(fault) && $stable(phys_addr))

endmodule

bind segmented_memory_access_unit smau_checker u_smau_checker (.*);

// ----- sim/segmented_memory_access_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Segmented memory access unit testbench
// Sends descriptor writes, byte reads and byte writes through the queue-style
// request port. A scoreboard keeps its own segment table and memory image,
// predicts the result of every accepted request, and compares each popped
// result with the oldest prediction. The sender and the receiver idle at
// random in the first two of three phases and never in the last.
// ----------------------------------------------------------------------------
module segmented_memory_access_unit_tb
  import smau_pkg::*;
;

  localparam int CYCLE_LIMIT      = 500000;
  localparam int ITEMS_PER_PHASE  = 609;
  localparam int DRAIN_CYCLES     = 16;
  localparam int HOT_LIST_DEPTH   = 2048;

  // One request as presented on the input ports.
  typedef struct packed {
    req_type_t   kind;
    logic [2:0]  slot;
    logic [15:0] ptr;
    logic [15:0] extra;
    logic [2:0]  count;
    logic [31:0] data;
    logic [15:0] desc_base;
    logic [15:0] desc_size;
  } request_t;

  // One result as seen on the output ports.
  typedef struct packed {
    logic [31:0] read_data;
    logic        fault;
    logic [15:0] phys;
  } result_t;

  // Segment table, memory image and the queue of predicted results.
  class access_checker;
    bit [31:0] seg_desc [SEGMENTS];
    bit [7:0]  mem_image [MEM_BYTES];
    bit        written [MEM_BYTES];
    int        hot_addrs [$];
    result_t   pending_results [$];
    int        errors;

    // Base plus both offsets, and whether every byte stays in segment and memory.
    function void translate(input request_t r, output logic [15:0] phys, output int cnt,
                            output bit ok);
      logic [15:0] base;
      logic [16:0] lim;
      logic [15:0] a;
      int          i;
      base = seg_desc[r.slot][31:16];
      lim  = {1'b0, base} + {1'b0, seg_desc[r.slot][15:0]};
      cnt  = (r.count > 4) ? 4 : int'(r.count);
      phys = base + r.ptr + r.extra;
      ok   = 1'b1;
      for (i = 0; i < cnt; i++) begin
        a = phys + 16'(i);
        if (a < base || {1'b0, a} >= lim || int'(a) >= MEM_BYTES) ok = 1'b0;
      end
    endfunction

    // True when a read would succeed but touch a byte never stored.
    function bit reads_unwritten(input request_t r);
      logic [15:0] phys;
      logic [15:0] a;
      int          cnt;
      int          i;
      bit          ok;
      if (r.kind != REQ_READ) return 1'b0;
      translate(r, phys, cnt, ok);
      if (!ok) return 1'b0;
      for (i = 0; i < cnt; i++) begin
        a = phys + 16'(i);
        if (!written[a]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Some slot whose segment holds the address, or -1.
    function int slot_holding(input int addr);
      int start;
      int k;
      int s;
      start = $urandom_range(0, SEGMENTS - 1);
      for (k = 0; k < SEGMENTS; k++) begin
        s = (start + k) % SEGMENTS;
        if (addr >= seg_desc[s][31:16] && addr < seg_desc[s][31:16] + seg_desc[s][15:0] &&
            addr < MEM_BYTES)
          return s;
      end
      return -1;
    endfunction

    // Apply an accepted request to the model state and queue its result.
    function void note_request(input request_t r);
      result_t     e;
      logic [15:0] phys;
      logic [15:0] a;
      int          cnt;
      int          i;
      bit          ok;
      e = '0;
      case (r.kind)
        REQ_DESC: begin
          seg_desc[r.slot] = {r.desc_base, r.desc_size};
        end
        REQ_READ, REQ_WRITE: begin
          translate(r, phys, cnt, ok);
          e.phys = phys;
          if (!ok) begin
            // A faulting access stores nothing and reads zero.
            e.fault = 1'b1;
          end else begin
            for (i = 0; i < cnt; i++) begin
              a = phys + 16'(i);
              if (r.kind == REQ_READ) begin
                e.read_data = {e.read_data[23:0], mem_image[a]};
              end else begin
                mem_image[a] = 8'(r.data >> (8 * (cnt - 1 - i)));
                written[a] = 1'b1;
                hot_addrs.push_back(int'(a));
                if (hot_addrs.size() > HOT_LIST_DEPTH) void'(hot_addrs.pop_front());
              end
            end
          end
        end
        default: begin
        end
      endcase
      pending_results.push_back(e);
    endfunction

    // Compare a popped result with the oldest prediction.
    function void check_result(input result_t got);
      result_t e;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting: read_data %h fault %b phys_addr %h",
                 $time, got.read_data, got.fault, got.phys);
        return;
      end
      e = pending_results.pop_front();
      if (e.read_data !== got.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, e.read_data, got.read_data);
      end
      if (e.fault !== got.fault) begin
        errors++;
        $display("%0t: fault expected %b actual %b", $time, e.fault, got.fault);
      end
      if (e.phys !== got.phys) begin
        errors++;
        $display("%0t: phys_addr expected %h actual %h", $time, e.phys, got.phys);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         req_type = REQ_NONE;
  logic [2:0]         seg_index = '0;
  logic signed [15:0] ptr_offset = '0;
  logic signed [15:0] extra_offset = '0;
  logic [2:0]         byte_count = '0;
  logic [31:0]        write_data = '0;
  logic [15:0]        desc_base = '0;
  logic [15:0]        desc_size = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [31:0]        read_data;
  logic               fault;
  logic [15:0]        phys_addr;

  access_checker sb = new();
  int            send_idle = 28;
  int            recv_idle = 86;
  int unsigned   cycle_count = 0;

  segmented_memory_access_unit dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req_type    (req_type),
    .seg_index   (seg_index),
    .ptr_offset  (ptr_offset),
    .extra_offset(extra_offset),
    .byte_count  (byte_count),
    .write_data  (write_data),
    .desc_base   (desc_base),
    .desc_size   (desc_size),
    .empty       (empty),
    .pop         (pop),
    .read_data   (read_data),
    .fault       (fault),
    .phys_addr   (phys_addr)
  );

  always #10 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: check on every accepted pop, then choose the next pop level.
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result('{read_data, fault, phys_addr});
    pop <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Offer one request after a random gap and hold it until it is accepted.
  task automatic send_request(input request_t r);
    while ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    req_type     <= r.kind;
    seg_index    <= r.slot;
    ptr_offset   <= r.ptr;
    extra_offset <= r.extra;
    byte_count   <= r.count;
    write_data   <= r.data;
    desc_base    <= r.desc_base;
    desc_size    <= r.desc_size;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(r);
  endtask

  function automatic request_t access_req(input req_type_t kind, input logic [2:0] slot,
                                          input logic [15:0] ptr, input logic [15:0] extra,
                                          input logic [2:0] cnt, input logic [31:0] data);
    request_t r;
    r       = '0;
    r.kind  = kind;
    r.slot  = slot;
    r.ptr   = ptr;
    r.extra = extra;
    r.count = cnt;
    r.data  = data;
    return r;
  endfunction

  function automatic request_t desc_req(input logic [2:0] slot, input logic [15:0] base,
                                        input logic [15:0] size);
    request_t r;
    r           = '0;
    r.kind      = REQ_DESC;
    r.slot      = slot;
    r.desc_base = base;
    r.desc_size = size;
    return r;
  endfunction

  // Mostly well-formed requests aimed at live segments and stored bytes,
  // with some noise that mostly faults.
  function automatic request_t random_request();
    request_t    r;
    int          roll;
    int          t;
    int          s;
    logic [31:0] d;
    r.kind      = req_type_t'($urandom_range(0, 3));
    r.slot      = 3'($urandom);
    r.ptr       = 16'($urandom);
    r.extra     = 16'($urandom);
    r.count     = 3'($urandom);
    r.data      = $urandom;
    r.desc_base = 16'($urandom);
    r.desc_size = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      r.kind = REQ_DESC;
      if (roll < 6) begin
        r.desc_base = 16'($urandom_range(0, MEM_BYTES - 1));
        r.desc_size = 16'($urandom_range(1, 300));
      end
    end else if (roll < 12) begin
      r.kind = REQ_NONE;
    end else begin
      r.kind = (roll < 56) ? REQ_WRITE : REQ_READ;
      if ($urandom_range(0, 99) < 85) r.count = 3'($urandom_range(1, 4));
      if ($urandom_range(0, 99) < 82) begin
        if (sb.hot_addrs.size() != 0 && (r.kind == REQ_READ || $urandom_range(0, 2) == 0)) begin
          t = sb.hot_addrs[$urandom_range(0, sb.hot_addrs.size() - 1)];
          s = sb.slot_holding(t);
          if (s >= 0) r.slot = 3'(s);
        end else begin
          d = sb.seg_desc[r.slot];
          t = d[31:16] + $urandom_range(0, (d[15:0] == 0) ? 0 : d[15:0] - 1);
        end
        // Split the distance to the target between the two offsets.
        d = sb.seg_desc[r.slot];
        r.ptr = 16'(t - int'(d[31:16]) - int'(r.extra));
      end
      if (sb.reads_unwritten(r)) r.kind = REQ_WRITE;
    end
    return r;
  endfunction

  // Main sequence: reset, directed requests, three random phases, drain.
  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Access through an empty descriptor faults.
    send_request(access_req(REQ_READ, 3'd0, 16'h0005, 16'h0003, 3'd2, 32'h0));
    send_request(desc_req(3'd0, 16'h0000, 16'h0010));
    // Big-endian write and reads of every width, offsets of both signs.
    send_request(access_req(REQ_WRITE, 3'd0, 16'h0000, 16'h0000, 3'd4, 32'hDEADBEEF));
    send_request(access_req(REQ_READ, 3'd0, 16'h0000, 16'h0000, 3'd4, 32'h0));
    send_request(access_req(REQ_READ, 3'd0, 16'h0001, 16'h0000, 3'd1, 32'h0));
    send_request(access_req(REQ_READ, 3'd0, 16'h0002, 16'hFFFF, 3'd3, 32'h0));
    send_request(access_req(REQ_READ, 3'd0, 16'h7FFF, 16'h8001, 3'd2, 32'h0));
    // Counts above four saturate; a count of zero touches nothing.
    send_request(access_req(REQ_WRITE, 3'd0, 16'h0004, 16'h0000, 3'd7, 32'h01234567));
    send_request(access_req(REQ_READ, 3'd0, 16'h0004, 16'h0000, 3'd5, 32'h0));
    send_request(access_req(REQ_READ, 3'd0, 16'h0004, 16'h0000, 3'd0, 32'h0));
    send_request(access_req(REQ_WRITE, 3'd0, 16'h0008, 16'h0000, 3'd0, 32'hFFFFFFFF));
    // A write that crosses the segment end stores no byte at all.
    send_request(access_req(REQ_WRITE, 3'd0, 16'h000C, 16'h0000, 3'd4, 32'hFFFFFFFF));
    send_request(access_req(REQ_WRITE, 3'd0, 16'h000E, 16'h0000, 3'd4, 32'h00000000));
    send_request(access_req(REQ_READ, 3'd0, 16'h000C, 16'h0000, 3'd4, 32'h0));
    // The unused request type changes nothing and returns zeros.
    send_request('{REQ_NONE, 3'd7, 16'hFFFF, 16'hFFFF, 3'd7, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF});
    // Address wrap at the top of the space, beyond memory.
    send_request(desc_req(3'd7, 16'hFFFF, 16'hFFFF));
    send_request(access_req(REQ_READ, 3'd7, 16'h0000, 16'h0000, 3'd2, 32'h0));
    // A segment that runs past the end of memory.
    send_request(desc_req(3'd3, 16'h3FFC, 16'd100));
    send_request(access_req(REQ_WRITE, 3'd3, 16'h0000, 16'h0000, 3'd4, 32'hA5A55A5A));
    send_request(access_req(REQ_WRITE, 3'd3, 16'h0002, 16'h0000, 3'd4, 32'h12345678));
    send_request(access_req(REQ_READ, 3'd3, 16'h8000, 16'h8000, 3'd4, 32'h0));
    send_request(desc_req(3'd1, 16'h0000, 16'hFFFF));
    send_request(access_req(REQ_WRITE, 3'd1, 16'h3FFF, 16'h0000, 3'd2, 32'h0000BEEF));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 28;
          recv_idle = 86;
        end
        1: begin
          send_idle = 86;
          recv_idle = 28;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_request(random_request());
    end
    push <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
